[design/bankers_safety_and_request_unit_assert.svh]
// assertion macros for the banker's safety and request unit
`ifndef BANKERS_SAFETY_AND_REQUEST_UNIT_ASSERT_SVH
`define BANKERS_SAFETY_AND_REQUEST_UNIT_ASSERT_SVH

// same-cycle implication
`define BSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bsr_pkg.sv]
`default_nettype none

package bsr_pkg;

    localparam int P_PROCESSES_DEF = 5;
    localparam int P_RESOURCES_DEF = 3;
    localparam int AMT_W           = 8;
    localparam int OP_W            = 3;
    localparam int PID_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int MAX_RESOURCES   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_MAX   = 3'd0,
        OP_LOAD_ALLOC = 3'd1,
        OP_LOAD_AVAIL = 3'd2,
        OP_REQUEST    = 3'd3,
        OP_CHECK      = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK            = 2'd0,
        STATUS_EXCEEDS_CLAIM = 2'd1,
        STATUS_NOT_AVAILABLE = 2'd2,
        STATUS_UNSAFE        = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_SCAN,
        S_ROLLBACK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic fits;
        logic over_need;
        logic over_avail;
    } t_fit_flags;

endpackage

`default_nettype wire

[design/bsr_store.sv]
`default_nettype none

module bsr_store
    import bsr_pkg::*;
#(
    parameter int PROCESSES = P_PROCESSES_DEF,
    parameter int RESOURCES = P_RESOURCES_DEF,
    parameter int ROW_W     = (PROCESSES > 1) ? $clog2(PROCESSES) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_max_we,
    input  wire logic                                i_alloc_we,
    input  wire logic                                i_avail_we,
    input  wire logic [ROW_W-1:0]                    i_wr_row,
    input  wire logic [RESOURCES-1:0][AMT_W-1:0]     i_row_data,
    input  wire logic [RESOURCES-1:0][AMT_W-1:0]     i_avail_data,
    input  wire logic [ROW_W-1:0]                    i_rd_row,
    output logic      [RESOURCES-1:0][AMT_W-1:0]     o_max_row,
    output logic      [RESOURCES-1:0][AMT_W-1:0]     o_alloc_row,
    output logic      [RESOURCES-1:0][AMT_W-1:0]     o_avail
);

    logic [RESOURCES-1:0][AMT_W-1:0] r_max   [PROCESSES];
    logic [RESOURCES-1:0][AMT_W-1:0] r_alloc [PROCESSES];
    logic [RESOURCES-1:0][AMT_W-1:0] r_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail <= '0;
            for (int p = 0; p < PROCESSES; p++) begin
                r_max[p]   <= '0;
                r_alloc[p] <= '0;
            end
        end else begin
            if (i_avail_we) begin
                r_avail <= i_avail_data;
            end
            for (int p = 0; p < PROCESSES; p++) begin
                if (i_max_we && (i_wr_row == ROW_W'(p))) begin
                    r_max[p] <= i_row_data;
                end
                if (i_alloc_we && (i_wr_row == ROW_W'(p))) begin
                    r_alloc[p] <= i_row_data;
                end
            end
        end
    end

    // rows beyond the process count read as zero
    always_comb begin
        o_max_row   = '0;
        o_alloc_row = '0;
        for (int p = 0; p < PROCESSES; p++) begin
            if (i_rd_row == ROW_W'(p)) begin
                o_max_row   = r_max[p];
                o_alloc_row = r_alloc[p];
            end
        end
    end

    assign o_avail = r_avail;

endmodule

`default_nettype wire

[design/bsr_fit_unit.sv]
`default_nettype none

module bsr_fit_unit
    import bsr_pkg::*;
#(
    parameter int RESOURCES = P_RESOURCES_DEF,
    parameter int WORK_W    = AMT_W + 3
) (
    input  wire logic [RESOURCES-1:0][AMT_W-1:0]  i_max_row,
    input  wire logic [RESOURCES-1:0][AMT_W-1:0]  i_alloc_row,
    input  wire logic [RESOURCES-1:0][AMT_W-1:0]  i_avail,
    input  wire logic [RESOURCES-1:0][AMT_W-1:0]  i_amt,
    input  wire logic [RESOURCES-1:0][WORK_W-1:0] i_work,
    output t_fit_flags                            o_flags,
    output logic      [RESOURCES-1:0][WORK_W-1:0] o_work_sum
);

    // need fits work  <=>  max <= work + alloc, no signed math needed
    always_comb begin
        logic [WORK_W:0] v_sum;
        logic [AMT_W:0]  v_req;
        o_flags.fits       = 1'b1;
        o_flags.over_need  = 1'b0;
        o_flags.over_avail = 1'b0;
        for (int r = 0; r < RESOURCES; r++) begin
            v_sum = {1'b0, i_work[r]} + (WORK_W+1)'(i_alloc_row[r]);
            if ((WORK_W+1)'(i_max_row[r]) > v_sum) begin
                o_flags.fits = 1'b0;
            end
            o_work_sum[r] = v_sum[WORK_W-1:0];
            v_req = {1'b0, i_amt[r]} + {1'b0, i_alloc_row[r]};
            if (v_req > {1'b0, i_max_row[r]}) begin
                o_flags.over_need = 1'b1;
            end
            if (i_amt[r] > i_avail[r]) begin
                o_flags.over_avail = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[design/bankers_safety_and_request_unit.sv]
// Banker's safety check and resource request unit.
// Command channel: an operation is transferred at a rising edge with start high
// and busy low; busy stays high until the last result of that command is
// driven and is low while it is on the ports. Operations: load max row,
// load alloc row, load available vector, request (checked against need and
// availability, applied, then rolled back if unsafe) and safety check.
// Result channel: each result is on the o_ ports for one cycle, flagged by
// o_strobe; o_last marks the final result of a command. The receiver cannot
// stall, so results are never held.
// Sequence: loads, refusals and unused codes give their single result from
// the execute state, registered onto the outputs. A check or granted request
// scans the process rows in passes until every process has finished or a
// pass makes no progress, then, if safe, drives PROCESSES sequence results,
// one per cycle; an unsafe request passes through a rollback state. The
// fit/add unit checks one row per cycle; a new command is taken only once busy is low.
// Reset clears the available vector, all rows and the sequencer; the block
// is ready as soon as reset is released.
`default_nettype none
`include "bankers_safety_and_request_unit_assert.svh"

module bankers_safety_and_request_unit
    import bsr_pkg::*;
#(
    parameter int PROCESSES = P_PROCESSES_DEF,
    parameter int RESOURCES = P_RESOURCES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [PID_W-1:0]    i_process,
    input  wire logic [AMT_W-1:0]    i_amount_0,
    input  wire logic [AMT_W-1:0]    i_amount_1,
    input  wire logic [AMT_W-1:0]    i_amount_2,
    input  wire logic [AMT_W-1:0]    i_amount_3,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_seq_valid,
    output logic [PID_W-1:0]         o_seq_process,
    output logic                     o_last
);

    localparam int ROW_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int CNT_W  = $clog2(PROCESSES + 1);
    localparam int WORK_W = AMT_W + CNT_W;
    localparam logic [PID_W:0]  PID_LIMIT = (PID_W+1)'(PROCESSES);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(PROCESSES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PROCESSES);

    t_state                            r_state, n_state;
    t_op                               r_op;
    logic [PID_W-1:0]                  r_pid;
    logic [RESOURCES-1:0][AMT_W-1:0]   r_amt;
    logic [RESOURCES-1:0][WORK_W-1:0]  r_work;
    logic [PROCESSES-1:0]              r_done;
    logic [CNT_W-1:0]                  r_count;
    logic [ROW_W-1:0]                  r_scan;
    logic                              r_progress;
    logic [PID_W-1:0]                  r_seq [PROCESSES];
    logic [ROW_W-1:0]                  r_out_idx;

    logic                              r_strobe;
    t_status                           r_status;
    logic                              r_seq_valid;
    logic [PID_W-1:0]                  r_seq_process;
    logic                              r_last;

    logic [MAX_RESOURCES-1:0][AMT_W-1:0] v_amt_in;
    logic [RESOURCES-1:0][AMT_W-1:0]   v_max_row, v_alloc_row, v_avail;
    logic [RESOURCES-1:0][AMT_W-1:0]   v_row_data, v_avail_data;
    logic [RESOURCES-1:0][WORK_W-1:0]  v_work_sum;
    t_fit_flags                        v_flags;
    logic [ROW_W-1:0]                  v_rd_row;
    logic                              v_max_we, v_alloc_we, v_avail_we;
    logic                              v_pid_ok, v_take, v_pass_end, v_prog_next;
    logic [CNT_W-1:0]                  v_count_next;
    logic                              v_emit, v_seq_valid, v_last;
    t_status                           v_status;
    logic [PID_W-1:0]                  v_seq_proc;

    assign v_amt_in = {i_amount_3, i_amount_2, i_amount_1, i_amount_0};
    assign busy     = (r_state != S_IDLE);
    assign v_pid_ok = ({1'b0, r_pid} < PID_LIMIT);
    assign v_rd_row = (r_state == S_SCAN) ? r_scan : r_pid[ROW_W-1:0];

    bsr_store #(
        .PROCESSES (PROCESSES),
        .RESOURCES (RESOURCES),
        .ROW_W     (ROW_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_we     (v_max_we),
        .i_alloc_we   (v_alloc_we),
        .i_avail_we   (v_avail_we),
        .i_wr_row     (r_pid[ROW_W-1:0]),
        .i_row_data   (v_row_data),
        .i_avail_data (v_avail_data),
        .i_rd_row     (v_rd_row),
        .o_max_row    (v_max_row),
        .o_alloc_row  (v_alloc_row),
        .o_avail      (v_avail)
    );

    bsr_fit_unit #(
        .RESOURCES (RESOURCES),
        .WORK_W    (WORK_W)
    ) u_fit (
        .i_max_row   (v_max_row),
        .i_alloc_row (v_alloc_row),
        .i_avail     (v_avail),
        .i_amt       (r_amt),
        .i_work      (r_work),
        .o_flags     (v_flags),
        .o_work_sum  (v_work_sum)
    );

    // scan step
    assign v_take       = !r_done[r_scan] && v_flags.fits;
    assign v_count_next = r_count + CNT_W'(v_take);
    assign v_prog_next  = r_progress | v_take;
    assign v_pass_end   = (r_scan == ROW_LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (r_op)
                    OP_REQUEST: begin
                        if (v_pid_ok && !v_flags.over_need && !v_flags.over_avail) begin
                            n_state = S_INIT;
                        end
                    end
                    OP_CHECK: n_state = S_INIT;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_INIT: n_state = S_SCAN;
            S_SCAN: begin
                if (v_count_next == CNT_FULL) begin
                    n_state = S_EMIT;
                end else if (v_pass_end && !v_prog_next) begin
                    n_state = (r_op == OP_REQUEST) ? S_ROLLBACK : S_IDLE;
                end
            end
            S_ROLLBACK: n_state = S_IDLE;
            S_EMIT: begin
                if (r_out_idx == ROW_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        v_max_we     = 1'b0;
        v_alloc_we   = 1'b0;
        v_avail_we   = 1'b0;
        v_row_data   = r_amt;
        v_avail_data = r_amt;
        v_emit       = 1'b0;
        v_status     = STATUS_OK;
        v_seq_valid  = 1'b0;
        v_seq_proc   = '0;
        v_last       = 1'b1;
        unique case (r_state)
            S_EXEC: begin
                unique case (r_op)
                    OP_LOAD_MAX: begin
                        v_max_we = v_pid_ok;
                        v_emit   = 1'b1;
                    end
                    OP_LOAD_ALLOC: begin
                        v_alloc_we = v_pid_ok;
                        v_emit     = 1'b1;
                    end
                    OP_LOAD_AVAIL: begin
                        v_avail_we = 1'b1;
                        v_emit     = 1'b1;
                    end
                    OP_REQUEST: begin
                        if (!v_pid_ok || v_flags.over_need) begin
                            v_emit   = 1'b1;
                            v_status = STATUS_EXCEEDS_CLAIM;
                        end else if (v_flags.over_avail) begin
                            v_emit   = 1'b1;
                            v_status = STATUS_NOT_AVAILABLE;
                        end else begin
                            v_alloc_we = 1'b1;
                            v_avail_we = 1'b1;
                            for (int r = 0; r < RESOURCES; r++) begin
                                v_row_data[r]   = v_alloc_row[r] + r_amt[r];
                                v_avail_data[r] = v_avail[r] - r_amt[r];
                            end
                        end
                    end
                    OP_CHECK: v_emit = 1'b0;
                    default:  v_emit = 1'b1;
                endcase
            end
            S_SCAN: begin
                if ((v_count_next != CNT_FULL) && v_pass_end && !v_prog_next
                        && (r_op != OP_REQUEST)) begin
                    v_emit   = 1'b1;
                    v_status = STATUS_UNSAFE;
                end
            end
            S_ROLLBACK: begin
                v_alloc_we = 1'b1;
                v_avail_we = 1'b1;
                for (int r = 0; r < RESOURCES; r++) begin
                    v_row_data[r]   = v_alloc_row[r] - r_amt[r];
                    v_avail_data[r] = v_avail[r] + r_amt[r];
                end
                v_emit   = 1'b1;
                v_status = STATUS_UNSAFE;
            end
            S_EMIT: begin
                v_emit      = 1'b1;
                v_seq_valid = 1'b1;
                v_seq_proc  = r_seq[r_out_idx];
                v_last      = (r_out_idx == ROW_LAST);
            end
            default: v_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= v_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_emit) begin
            r_status      <= v_status;
            r_seq_valid   <= v_seq_valid;
            r_seq_process <= v_seq_proc;
            r_last        <= v_last;
        end
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_op  <= t_op'(i_operation);
                    r_pid <= i_process;
                    for (int r = 0; r < RESOURCES; r++) begin
                        r_amt[r] <= v_amt_in[r];
                    end
                end
            end
            S_INIT: begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_work[r] <= WORK_W'(v_avail[r]);
                end
                r_done     <= '0;
                r_count    <= '0;
                r_scan     <= '0;
                r_progress <= 1'b0;
                r_out_idx  <= '0;
            end
            S_SCAN: begin
                if (v_take) begin
                    r_work                      <= v_work_sum;
                    r_done[r_scan]              <= 1'b1;
                    r_seq[r_count[ROW_W-1:0]]   <= PID_W'(r_scan);
                end
                r_count <= v_count_next;
                if (v_pass_end) begin
                    r_scan     <= '0;
                    r_progress <= 1'b0;
                end else begin
                    r_scan     <= r_scan + ROW_W'(1);
                    r_progress <= v_prog_next;
                end
            end
            S_EMIT: r_out_idx <= r_out_idx + ROW_W'(1);
            default: r_out_idx <= r_out_idx;
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_seq_valid   = r_seq_valid;
    assign o_seq_process = r_seq_process;
    assign o_last        = r_last;

    `BSR_ASSERT_NXT(a_transfer_busy, i_clk, i_rst_n, start && !busy, busy, "transfer did not raise busy")
    `BSR_ASSERT_IMP(a_done_count, i_clk, i_rst_n, r_state == S_SCAN, $countones(r_done) == int'(r_count), "done bits disagree with count")
    `BSR_ASSERT_IMP(a_last_frees, i_clk, i_rst_n, o_strobe && o_last, !busy, "busy after final result")
    `BSR_ASSERT_IMP(a_single_last, i_clk, i_rst_n, o_strobe && !o_seq_valid, o_last, "non-sequence result not final")
    `BSR_ASSERT_IMP(a_seq_ok, i_clk, i_rst_n, o_strobe && o_seq_valid, o_status == STATUS_OK, "sequence entry with bad status")

endmodule

`default_nettype wire

[verif/bankers_safety_and_request_unit_tb.sv]
`timescale 1ns / 100ps

module bankers_safety_and_request_unit_tb;
    import bsr_pkg::*;

    localparam int NPROC        = P_PROCESSES_DEF;
    localparam int NRES         = P_RESOURCES_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_TAIL   = 60;
    localparam int DRAIN_CYCLES = 3 + NPROC * (NPROC + 1) + NPROC + 8;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                seq_valid;
        logic [PID_W-1:0]    seq_process;
        logic                last;
    } t_result;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_STATUS,
        CHK_ORDER
    } t_row_check;

    typedef struct packed {
        logic [OP_W-1:0]                         op;
        logic [PID_W-1:0]                        pid;
        logic [MAX_RESOURCES-1:0][AMT_W-1:0]     amt;
        t_row_check                              chk;
        t_status                                 status;
    } t_cmd_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_operation;
    logic [PID_W-1:0]    i_process;
    logic [AMT_W-1:0]    i_amount_0;
    logic [AMT_W-1:0]    i_amount_1;
    logic [AMT_W-1:0]    i_amount_2;
    logic [AMT_W-1:0]    i_amount_3;
    logic                o_strobe;
    logic [STATUS_W-1:0] o_status;
    logic                o_seq_valid;
    logic [PID_W-1:0]    o_seq_process;
    logic                o_last;

    // banker state as the block should hold it
    logic [AMT_W-1:0] free_units [NRES];
    logic [AMT_W-1:0] claim_row [NPROC][NRES];
    logic [AMT_W-1:0] held_row [NPROC][NRES];
    logic [PID_W-1:0] safe_order [NPROC];

    t_result  step_results[$];
    t_result  pending_results[$];
    t_cmd_row directed_rows[$];
    int       mismatch_count;

    bankers_safety_and_request_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_process     (i_process),
        .i_amount_0    (i_amount_0),
        .i_amount_1    (i_amount_1),
        .i_amount_2    (i_amount_2),
        .i_amount_3    (i_amount_3),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_seq_valid   (o_seq_valid),
        .o_seq_process (o_seq_process),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_result make_result(t_status st, bit sv, int pidx, bit lst);
        t_result res;
        res.status      = st;
        res.seq_valid   = sv;
        res.seq_process = PID_W'(pidx);
        res.last        = lst;
        return res;
    endfunction

    function automatic int unit_need(int p, int r);
        return int'(claim_row[p][r]) - int'(held_row[p][r]);
    endfunction

    // repeated passes in index order over a private work vector
    function automatic bit run_safety_scan();
        int work [NRES];
        bit finished [NPROC];
        int count;
        bit progress;
        bit fits;
        count = 0;
        for (int r = 0; r < NRES; r++) work[r] = int'(free_units[r]);
        for (int p = 0; p < NPROC; p++) finished[p] = 1'b0;
        while (count < NPROC) begin
            progress = 1'b0;
            for (int p = 0; p < NPROC; p++) begin
                if (!finished[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < NRES; r++) begin
                        if (unit_need(p, r) > work[r]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int r = 0; r < NRES; r++) work[r] += int'(held_row[p][r]);
                        finished[p] = 1'b1;
                        safe_order[count] = PID_W'(p);
                        count++;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void emit_safe_order();
        for (int k = 0; k < NPROC; k++)
            step_results.push_back(make_result(STATUS_OK, 1'b1, int'(safe_order[k]),
                                               k == NPROC - 1));
    endfunction

    function automatic void apply_command(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                                          logic [MAX_RESOURCES-1:0][AMT_W-1:0] amt);
        t_status verdict;
        step_results.delete();
        verdict = STATUS_OK;
        case (op)
            OP_LOAD_MAX, OP_LOAD_ALLOC: begin
                if (pid < NPROC) begin
                    for (int r = 0; r < NRES; r++) begin
                        if (op == OP_LOAD_MAX) claim_row[pid][r] = amt[r];
                        else held_row[pid][r] = amt[r];
                    end
                end
                step_results.push_back(make_result(STATUS_OK, 1'b0, 0, 1'b1));
            end
            OP_LOAD_AVAIL: begin
                for (int r = 0; r < NRES; r++) free_units[r] = amt[r];
                step_results.push_back(make_result(STATUS_OK, 1'b0, 0, 1'b1));
            end
            OP_REQUEST: begin
                if (pid >= NPROC) begin
                    verdict = STATUS_EXCEEDS_CLAIM;
                end else begin
                    for (int r = 0; r < NRES; r++)
                        if (int'(amt[r]) > unit_need(pid, r)) verdict = STATUS_EXCEEDS_CLAIM;
                    if (verdict == STATUS_OK)
                        for (int r = 0; r < NRES; r++)
                            if (amt[r] > free_units[r]) verdict = STATUS_NOT_AVAILABLE;
                end
                if (verdict == STATUS_OK) begin
                    for (int r = 0; r < NRES; r++) begin
                        free_units[r]    = free_units[r] - amt[r];
                        held_row[pid][r] = held_row[pid][r] + amt[r];
                    end
                    if (run_safety_scan()) begin
                        emit_safe_order();
                    end else begin
                        for (int r = 0; r < NRES; r++) begin
                            free_units[r]    = free_units[r] + amt[r];
                            held_row[pid][r] = held_row[pid][r] - amt[r];
                        end
                        verdict = STATUS_UNSAFE;
                    end
                end
                if (verdict != STATUS_OK)
                    step_results.push_back(make_result(verdict, 1'b0, 0, 1'b1));
            end
            OP_CHECK: begin
                if (run_safety_scan()) emit_safe_order();
                else step_results.push_back(make_result(STATUS_UNSAFE, 1'b0, 0, 1'b1));
            end
            default: begin
                step_results.push_back(make_result(STATUS_OK, 1'b0, 0, 1'b1));
            end
        endcase
    endfunction

    function automatic t_cmd_row make_row(logic [OP_W-1:0] op, int pid, int a0, int a1,
                                          int a2, int a3, t_row_check chk, t_status st);
        t_cmd_row row;
        row.op     = op;
        row.pid    = PID_W'(pid);
        row.amt[0] = AMT_W'(a0);
        row.amt[1] = AMT_W'(a1);
        row.amt[2] = AMT_W'(a2);
        row.amt[3] = AMT_W'(a3);
        row.chk    = chk;
        row.status = st;
        return row;
    endfunction

    function automatic logic [AMT_W-1:0] random_amount();
        if ($urandom_range(0, 3) == 0) return AMT_W'($urandom_range(0, 255));
        return AMT_W'($urandom_range(0, 15));
    endfunction

    // mostly well-formed: allocations within claims, requests within need and stock
    function automatic void pick_random_command(output logic [OP_W-1:0] op,
                                                output logic [PID_W-1:0] pid,
                                                output logic [MAX_RESOURCES-1:0][AMT_W-1:0] amt);
        int sel;
        int p;
        int lim;
        sel = $urandom_range(0, 99);
        p = $urandom_range(0, NPROC - 1);
        if ($urandom_range(0, 19) == 0) p = $urandom_range(NPROC, 7);
        pid = PID_W'(p);
        for (int r = 0; r < MAX_RESOURCES; r++) amt[r] = random_amount();
        if (sel < 14) begin
            op = OP_LOAD_MAX;
        end else if (sel < 24) begin
            op = OP_LOAD_ALLOC;
            if (p < NPROC && $urandom_range(0, 4) != 0)
                for (int r = 0; r < NRES; r++)
                    amt[r] = AMT_W'($urandom_range(0, int'(claim_row[p][r])));
        end else if (sel < 32) begin
            op = OP_LOAD_AVAIL;
        end else if (sel < 74) begin
            op = OP_REQUEST;
            if (p < NPROC && $urandom_range(0, 3) != 0) begin
                for (int r = 0; r < NRES; r++) begin
                    lim = unit_need(p, r);
                    if ($urandom_range(0, 3) != 0 && lim > int'(free_units[r]))
                        lim = int'(free_units[r]);
                    if (lim < 0) lim = 0;
                    amt[r] = AMT_W'($urandom_range(0, lim));
                end
            end
        end else if (sel < 94) begin
            op = OP_CHECK;
        end else begin
            op = OP_SPARE_A + OP_W'($urandom_range(0, 2));
        end
    endfunction

    task automatic send_command(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                                input logic [MAX_RESOURCES-1:0][AMT_W-1:0] amt,
                                input t_row_check chk, input t_status st);
        i_operation <= op;
        i_process   <= pid;
        i_amount_0  <= amt[0];
        i_amount_1  <= amt[1];
        i_amount_2  <= amt[2];
        i_amount_3  <= amt[3];
        start       <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_command(op, pid, amt);
        case (chk)
            CHK_STATUS: pending_results.push_back(make_result(st, 1'b0, 0, 1'b1));
            CHK_ORDER: begin
                for (int k = 0; k < NPROC; k++)
                    pending_results.push_back(make_result(STATUS_OK, 1'b1, k, k == NPROC - 1));
            end
            default: begin
                foreach (step_results[k]) pending_results.push_back(step_results[k]);
            end
        endcase
    endtask

    task automatic maybe_idle(input bit allowed);
        if (allowed && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: status %0d seq_valid %0d seq_process %0d last %0d",
                             o_status, o_seq_valid, o_seq_process, o_last);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_seq_valid !== want.seq_valid ||
                    o_seq_process !== want.seq_process || o_last !== want.last) begin
                    if (mismatch_count < 10)
                        $display("mismatch at %0t: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 $realtime, want.status, want.seq_valid, want.seq_process,
                                 want.last, o_status, o_seq_valid, o_seq_process, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [OP_W-1:0]                     op;
        logic [PID_W-1:0]                    pid;
        logic [MAX_RESOURCES-1:0][AMT_W-1:0] amt;
        mismatch_count = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_LOAD_MAX;
        i_process   <= '0;
        i_amount_0  <= '0;
        i_amount_1  <= '0;
        i_amount_2  <= '0;
        i_amount_3  <= '0;
        for (int r = 0; r < NRES; r++) free_units[r] = '0;
        for (int p = 0; p < NPROC; p++)
            for (int r = 0; r < NRES; r++) begin
                claim_row[p][r] = '0;
                held_row[p][r]  = '0;
            end

        // empty state is safe in index order
        directed_rows.push_back(make_row(OP_CHECK, 0, 0, 0, 0, 0, CHK_ORDER, STATUS_OK));
        directed_rows.push_back(make_row(OP_LOAD_MAX, 0, 255, 255, 255, 255, CHK_STATUS,
                                         STATUS_OK));
        directed_rows.push_back(make_row(OP_CHECK, 3, 0, 0, 0, 0, CHK_STATUS, STATUS_UNSAFE));
        directed_rows.push_back(make_row(OP_LOAD_AVAIL, 0, 255, 255, 255, 170, CHK_STATUS,
                                         STATUS_OK));
        directed_rows.push_back(make_row(OP_CHECK, 0, 0, 0, 0, 0, CHK_ORDER, STATUS_OK));
        directed_rows.push_back(make_row(OP_REQUEST, 0, 0, 0, 0, 255, CHK_ORDER, STATUS_OK));
        directed_rows.push_back(make_row(OP_REQUEST, 0, 255, 255, 255, 0, CHK_MODEL,
                                         STATUS_OK));
        directed_rows.push_back(make_row(OP_REQUEST, 1, 1, 0, 0, 0, CHK_STATUS,
                                         STATUS_EXCEEDS_CLAIM));
        directed_rows.push_back(make_row(OP_LOAD_MAX, 1, 10, 10, 10, 0, CHK_STATUS, STATUS_OK));
        directed_rows.push_back(make_row(OP_REQUEST, 1, 1, 0, 0, 0, CHK_STATUS,
                                         STATUS_NOT_AVAILABLE));
        // allocation above claim: negative need
        directed_rows.push_back(make_row(OP_LOAD_ALLOC, 2, 50, 0, 0, 0, CHK_STATUS, STATUS_OK));
        directed_rows.push_back(make_row(OP_REQUEST, 2, 0, 0, 0, 0, CHK_STATUS,
                                         STATUS_EXCEEDS_CLAIM));
        directed_rows.push_back(make_row(OP_CHECK, 2, 0, 0, 0, 0, CHK_MODEL, STATUS_OK));
        // out of range process
        directed_rows.push_back(make_row(OP_LOAD_MAX, 5, 9, 9, 9, 9, CHK_STATUS, STATUS_OK));
        directed_rows.push_back(make_row(OP_LOAD_ALLOC, 7, 200, 200, 200, 200, CHK_STATUS,
                                         STATUS_OK));
        directed_rows.push_back(make_row(OP_REQUEST, 6, 0, 0, 0, 0, CHK_STATUS,
                                         STATUS_EXCEEDS_CLAIM));
        directed_rows.push_back(make_row(OP_REQUEST, 7, 0, 0, 0, 0, CHK_STATUS,
                                         STATUS_EXCEEDS_CLAIM));
        // unused operation codes
        directed_rows.push_back(make_row(OP_SPARE_A, 1, 255, 0, 255, 0, CHK_STATUS, STATUS_OK));
        directed_rows.push_back(make_row(OP_SPARE_B, 4, 0, 255, 0, 255, CHK_STATUS, STATUS_OK));
        directed_rows.push_back(make_row(OP_SPARE_C, 7, 255, 255, 255, 255, CHK_STATUS,
                                         STATUS_OK));
        // unsafe request is rolled back
        directed_rows.push_back(make_row(OP_LOAD_AVAIL, 0, 5, 5, 5, 85, CHK_STATUS, STATUS_OK));
        directed_rows.push_back(make_row(OP_LOAD_ALLOC, 0, 0, 0, 0, 0, CHK_STATUS, STATUS_OK));
        directed_rows.push_back(make_row(OP_REQUEST, 1, 5, 5, 5, 0, CHK_MODEL, STATUS_OK));
        directed_rows.push_back(make_row(OP_CHECK, 4, 0, 0, 0, 0, CHK_MODEL, STATUS_OK));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].op, directed_rows[i].pid, directed_rows[i].amt,
                         directed_rows[i].chk, directed_rows[i].status);
            maybe_idle(1'b1);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick_random_command(op, pid, amt);
            send_command(op, pid, amt, CHK_MODEL, STATUS_OK);
            maybe_idle(n < RANDOM_ITEMS - QUIET_TAIL && (n / 40) % 3 != 2);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[bankers_safety_and_request_unit.f]
+incdir+design
design/bsr_pkg.sv
design/bsr_store.sv
design/bsr_fit_unit.sv
design/bankers_safety_and_request_unit.sv
verif/bankers_safety_and_request_unit_tb.sv
